// File: src/tcc_pkg.sv
// ---------------------------------------------------------------------------
// tcc_pkg
// Shared constants, tag types and result type of the triangle circumcircle
// pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // default geometry of the datapath
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // fixed port widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 32;

    // input coordinates are zero padded to this width before the low bits are taken
    localparam int EXT_W = 40;

    // offset magnitude is held at 2^OFS_LOG
    localparam int OFS_LOG = 60;
    localparam int QC_W    = OFS_LOG + 1;
    localparam int OFS_W   = OFS_LOG + 2;
    localparam int CEN_W   = 64;

    // square root unit
    localparam int SQ_W     = 2 * OUT_W + 2;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = ROOT_W + 2;

    // flags that ride along with the divider lanes
    typedef struct packed {
        logic degen;
        logic xneg;
        logic yneg;
    } tcc_tag_t;

    // flags that ride along with the square root stages
    typedef struct packed {
        logic degen;
        logic sat;
        logic rbig;
    } tcc_rtag_t;

    // one result beat
    typedef struct packed {
        logic [OUT_W-1:0] center_x;
        logic [OUT_W-1:0] center_y;
        logic [OUT_W-1:0] radius;
        logic             degenerate;
        logic             saturated;
    } tcc_res_t;

endpackage

`default_nettype wire

// File: src/triangle_circumcircle_top.sv
// ---------------------------------------------------------------------------
// triangle_circumcircle_top
// Circumcenter and circumradius of a triangle in fixed point, fully pipelined.
//
//   channel  | direction | ports
//   ---------+-----------+----------------------------------------------------
//   s_       | in        | s_valid s_ready s_ax s_ay s_bx s_by_coord s_cx s_cy
//   m_       | out       | m_valid m_ready m_center_x m_center_y m_radius
//            |           | m_degenerate m_saturated
//
// One triangle enters per cycle while s_ready is high. The pipeline is 6 front
// stages, one divider stage per numerator bit, 2 post stages, 33 square root
// stages and the output register.
// Reset is synchronous and clears only the valid bits and the output buffer's valid flags.
// A stalled output fills a one-beat skid buffer; only then does the whole
// pipeline hold and s_ready drop, so no beat is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_circumcircle_top #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [tcc_pkg::IN_W-1:0] s_ax,
    input  logic signed [tcc_pkg::IN_W-1:0] s_ay,
    input  logic signed [tcc_pkg::IN_W-1:0] s_bx,
    input  logic signed [tcc_pkg::IN_W-1:0] s_by_coord,
    input  logic signed [tcc_pkg::IN_W-1:0] s_cx,
    input  logic signed [tcc_pkg::IN_W-1:0] s_cy,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [tcc_pkg::OUT_W-1:0] m_center_x,
    output logic signed [tcc_pkg::OUT_W-1:0] m_center_y,
    output logic [tcc_pkg::OUT_W-1:0]       m_radius,
    output logic                            m_degenerate,
    output logic                            m_saturated
);
    import tcc_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int NUM_W  = 3 * C + 3 + FRAC_BITS;
    localparam int DEN_W  = 2 * C + 2;
    localparam int SIDE_W = 2 * C;
    localparam int QE_W   = (NUM_W > QC_W) ? NUM_W : QC_W;

    logic en;

    // front end
    logic                fr_vld;
    logic [NUM_W-1:0]    fr_num_x, fr_num_y;
    logic [DEN_W-1:0]    fr_den;
    tcc_tag_t            fr_tag;
    logic signed [C-1:0] fr_ax, fr_ay;

    tcc_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .in_vld (s_valid),
        .ax_in  (s_ax),
        .ay_in  (s_ay),
        .bx_in  (s_bx),
        .by_in  (s_by_coord),
        .cx_in  (s_cx),
        .cy_in  (s_cy),
        .out_vld(fr_vld),
        .num_x  (fr_num_x),
        .num_y  (fr_num_y),
        .den    (fr_den),
        .tag    (fr_tag),
        .ax_out (fr_ax),
        .ay_out (fr_ay)
    );

    // offset dividers
    logic              dv_vld;
    logic [NUM_W-1:0]  dv_qx, dv_qy;
    tcc_tag_t          dv_tag;
    logic [SIDE_W-1:0] dv_side;

    tcc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .SIDE_W(SIDE_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (fr_vld),
        .num_x   (fr_num_x),
        .num_y   (fr_num_y),
        .den     (fr_den),
        .tag_in  (fr_tag),
        .side_in ({fr_ax, fr_ay}),
        .out_vld (dv_vld),
        .q_x     (dv_qx),
        .q_y     (dv_qy),
        .tag_out (dv_tag),
        .side_out(dv_side)
    );

    // post stage 1: clamp offsets, form centers, square offsets
    logic [QE_W-1:0]         qxe, qye;
    logic                    ovfx, ovfy;
    logic [QC_W-1:0]         qxc, qyc;
    logic signed [OFS_W-1:0] oxp, oyp, oxs, oys;
    logic signed [C-1:0]     dax, day;
    logic signed [CEN_W-1:0] axf, ayf;

    assign qxe  = QE_W'(dv_qx);
    assign qye  = QE_W'(dv_qy);
    assign ovfx = |qxe[QE_W-1:OFS_LOG];
    assign ovfy = |qye[QE_W-1:OFS_LOG];
    assign qxc  = ovfx ? {1'b1, {OFS_LOG{1'b0}}} : qxe[QC_W-1:0];
    assign qyc  = ovfy ? {1'b1, {OFS_LOG{1'b0}}} : qye[QC_W-1:0];
    assign oxp  = {1'b0, qxc};
    assign oyp  = {1'b0, qyc};
    assign oxs  = dv_tag.xneg ? -oxp : oxp;
    assign oys  = dv_tag.yneg ? -oyp : oyp;
    assign dax  = dv_side[SIDE_W-1:C];
    assign day  = dv_side[C-1:0];
    assign axf  = {{(CEN_W-C){dax[C-1]}}, dax} <<< FRAC_BITS;
    assign ayf  = {{(CEN_W-C){day[C-1]}}, day} <<< FRAC_BITS;

    logic                    p1_vld_reg;
    logic [2*OUT_W-1:0]      p1_sqx_reg, p1_sqy_reg;
    logic signed [CEN_W-1:0] p1_cx_reg, p1_cy_reg;
    logic                    p1_sat_reg, p1_rbig_reg, p1_degen_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sqx_reg   <= qxc[OUT_W-1:0] * qxc[OUT_W-1:0];
            p1_sqy_reg   <= qyc[OUT_W-1:0] * qyc[OUT_W-1:0];
            p1_cx_reg    <= axf + {{(CEN_W-OFS_W){oxs[OFS_W-1]}}, oxs};
            p1_cy_reg    <= ayf + {{(CEN_W-OFS_W){oys[OFS_W-1]}}, oys};
            p1_sat_reg   <= ovfx | ovfy;
            p1_rbig_reg  <= (|qxc[QC_W-1:OUT_W]) | (|qyc[QC_W-1:OUT_W]);
            p1_degen_reg <= dv_tag.degen;
        end
    end

    // post stage 2: clip centers to 32 bits, sum of squares
    function automatic logic [OUT_W:0] clip_center(input logic signed [CEN_W-1:0] v);
        logic             ov;
        logic [OUT_W-1:0] val;
        ov  = !((&v[CEN_W-1:OUT_W-1]) || !(|v[CEN_W-1:OUT_W-1]));
        val = v[OUT_W-1:0];
        if (ov) begin
            val = v[CEN_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return {ov, val};
    endfunction

    logic [OUT_W:0] clx, cly;

    assign clx = clip_center(p1_cx_reg);
    assign cly = clip_center(p1_cy_reg);

    logic             p2_vld_reg;
    logic [SQ_W-1:0]  p2_sq_reg;
    logic [OUT_W-1:0] p2_cx_reg, p2_cy_reg;
    tcc_rtag_t        p2_tag_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_sq_reg        <= SQ_W'(p1_sqx_reg) + SQ_W'(p1_sqy_reg);
            p2_cx_reg        <= clx[OUT_W-1:0];
            p2_cy_reg        <= cly[OUT_W-1:0];
            p2_tag_reg.degen <= p1_degen_reg;
            p2_tag_reg.sat   <= p1_sat_reg | clx[OUT_W] | cly[OUT_W] | p1_rbig_reg;
            p2_tag_reg.rbig  <= p1_rbig_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= dv_vld;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    // radius square root
    logic               sq_vld;
    logic [ROOT_W-1:0]  sq_root;
    logic [REM_W-1:0]   sq_rem;
    tcc_rtag_t          sq_tag;
    logic [2*OUT_W-1:0] sq_side;

    tcc_sqrt #(
        .SIDE_W(2 * OUT_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (p2_vld_reg),
        .sq_in   (p2_sq_reg),
        .tag_in  (p2_tag_reg),
        .side_in ({p2_cx_reg, p2_cy_reg}),
        .out_vld (sq_vld),
        .root    (sq_root),
        .rem     (sq_rem),
        .tag_out (sq_tag),
        .side_out(sq_side)
    );

    // final rounding of the radius and result assembly
    logic [ROOT_W:0] rnd;
    logic            rclip;
    tcc_res_t        res_next;

    assign rnd   = {1'b0, sq_root} + (ROOT_W+1)'(sq_rem > REM_W'(sq_root));
    assign rclip = |rnd[ROOT_W:OUT_W];

    always_comb begin
        res_next.center_x   = sq_side[2*OUT_W-1:OUT_W];
        res_next.center_y   = sq_side[OUT_W-1:0];
        res_next.radius     = (sq_tag.rbig || rclip) ? '1 : rnd[OUT_W-1:0];
        res_next.degenerate = 1'b0;
        res_next.saturated  = sq_tag.sat | (!sq_tag.rbig & rclip);
        if (sq_tag.degen) begin
            res_next.center_x   = '0;
            res_next.center_y   = '0;
            res_next.radius     = '0;
            res_next.degenerate = 1'b1;
            res_next.saturated  = 1'b0;
        end
    end

    // output register with one-beat skid buffer
    logic     out_vld_reg, skid_vld_reg;
    tcc_res_t out_reg, skid_reg;
    logic     push, pop;

    assign en   = !skid_vld_reg;
    assign push = en && sq_vld;
    assign pop  = out_vld_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_vld_reg || pop) begin
                out_reg <= res_next;
            end else begin
                skid_reg <= res_next;
            end
        end
    end

    assign s_ready      = en;
    assign m_valid      = out_vld_reg;
    assign m_center_x   = out_reg.center_x;
    assign m_center_y   = out_reg.center_y;
    assign m_radius     = out_reg.radius;
    assign m_degenerate = out_reg.degenerate;
    assign m_saturated  = out_reg.saturated;

endmodule

`default_nettype wire

// File: src/tcc_front.sv
// ---------------------------------------------------------------------------
// tcc_front
// Front end: edge vectors, cross product, squared lengths and the two
// numerators, cut into six register stages, ending in divider operands.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_front #(
    parameter int COORD_BITS = tcc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tcc_pkg::FRAC_BITS_DEF,
    parameter int NUM_W      = 3 * COORD_BITS + 3 + FRAC_BITS,
    parameter int DEN_W      = 2 * COORD_BITS + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [tcc_pkg::IN_W-1:0]     ax_in,
    input  logic [tcc_pkg::IN_W-1:0]     ay_in,
    input  logic [tcc_pkg::IN_W-1:0]     bx_in,
    input  logic [tcc_pkg::IN_W-1:0]     by_in,
    input  logic [tcc_pkg::IN_W-1:0]     cx_in,
    input  logic [tcc_pkg::IN_W-1:0]     cy_in,
    output logic                         out_vld,
    output logic [NUM_W-1:0]             num_x,
    output logic [NUM_W-1:0]             num_y,
    output logic [DEN_W-1:0]             den,
    output tcc_pkg::tcc_tag_t            tag,
    output logic signed [COORD_BITS-1:0] ax_out,
    output logic signed [COORD_BITS-1:0] ay_out
);
    import tcc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int UW   = C + 1;
    localparam int PW   = 2 * UW;
    localparam int DSW  = 2 * C + 3;
    localparam int LW   = 2 * C + 1;
    localparam int K    = C + 1;
    localparam int HW   = LW - K;
    localparam int MW   = 2 * C + 3;
    localparam int NSW  = 3 * C + 4;
    localparam int MAGW = 3 * C + 2;

    function automatic logic signed [C-1:0] take_low(input logic [IN_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[C-1:0];
    endfunction

    function automatic logic signed [NSW-1:0] widen(input logic signed [MW-1:0] v);
        return {{(NSW-MW){v[MW-1]}}, v};
    endfunction

    logic [5:0] vld_reg;

    // stage 0: coordinates and edge vectors
    logic signed [C-1:0]  ax_c, ay_c, bx_c, by_c, cx_c, cy_c;
    logic signed [UW-1:0] ux_next, uy_next, vx_next, vy_next;
    logic signed [C-1:0]  a0x_reg, a0y_reg;
    logic signed [UW-1:0] ux0_reg, uy0_reg, vx0_reg, vy0_reg;

    assign ax_c = take_low(ax_in);
    assign ay_c = take_low(ay_in);
    assign bx_c = take_low(bx_in);
    assign by_c = take_low(by_in);
    assign cx_c = take_low(cx_in);
    assign cy_c = take_low(cy_in);
    assign ux_next = {bx_c[C-1], bx_c} - {ax_c[C-1], ax_c};
    assign uy_next = {by_c[C-1], by_c} - {ay_c[C-1], ay_c};
    assign vx_next = {cx_c[C-1], cx_c} - {ax_c[C-1], ax_c};
    assign vy_next = {cy_c[C-1], cy_c} - {ay_c[C-1], ay_c};

    always_ff @(posedge aclk) begin
        if (en) begin
            a0x_reg <= ax_c;
            a0y_reg <= ay_c;
            ux0_reg <= ux_next;
            uy0_reg <= uy_next;
            vx0_reg <= vx_next;
            vy0_reg <= vy_next;
        end
    end

    // stage 1: cross terms and squares
    logic signed [C-1:0]  a1x_reg, a1y_reg;
    logic signed [UW-1:0] ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic signed [PW-1:0] puv1_reg, pvu1_reg, sux1_reg, suy1_reg, svx1_reg, svy1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a1x_reg  <= a0x_reg;
            a1y_reg  <= a0y_reg;
            ux1_reg  <= ux0_reg;
            uy1_reg  <= uy0_reg;
            vx1_reg  <= vx0_reg;
            vy1_reg  <= vy0_reg;
            puv1_reg <= ux0_reg * vy0_reg;
            pvu1_reg <= uy0_reg * vx0_reg;
            sux1_reg <= ux0_reg * ux0_reg;
            suy1_reg <= uy0_reg * uy0_reg;
            svx1_reg <= vx0_reg * vx0_reg;
            svy1_reg <= vy0_reg * vy0_reg;
        end
    end

    // stage 2: cross product and squared lengths
    logic signed [C-1:0]   a2x_reg, a2y_reg;
    logic signed [UW-1:0]  ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    logic signed [DSW-1:0] d2_reg;
    logic [LW-1:0]         lu2_reg, lv2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a2x_reg <= a1x_reg;
            a2y_reg <= a1y_reg;
            ux2_reg <= ux1_reg;
            uy2_reg <= uy1_reg;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            d2_reg  <= {puv1_reg[PW-1], puv1_reg} - {pvu1_reg[PW-1], pvu1_reg};
            lu2_reg <= sux1_reg[LW-1:0] + suy1_reg[LW-1:0];
            lv2_reg <= svx1_reg[LW-1:0] + svy1_reg[LW-1:0];
        end
    end

    // stage 3: |d| and split partial products of the numerators
    logic signed [DSW-1:0] dneg_val;
    logic signed [K:0]     lul_s, lvl_s;
    logic signed [HW:0]    luh_s, lvh_s;
    logic signed [C-1:0]   a3x_reg, a3y_reg;
    logic [LW-1:0]         dmag3_reg;
    logic                  dneg3_reg, degen3_reg;
    logic signed [MW-1:0]  plx1_reg, plx2_reg, phx1_reg, phx2_reg;
    logic signed [MW-1:0]  ply1_reg, ply2_reg, phy1_reg, phy2_reg;

    assign dneg_val = -d2_reg;
    assign lul_s = {1'b0, lu2_reg[K-1:0]};
    assign lvl_s = {1'b0, lv2_reg[K-1:0]};
    assign luh_s = {1'b0, lu2_reg[LW-1:K]};
    assign lvh_s = {1'b0, lv2_reg[LW-1:K]};

    always_ff @(posedge aclk) begin
        if (en) begin
            a3x_reg    <= a2x_reg;
            a3y_reg    <= a2y_reg;
            dmag3_reg  <= d2_reg[DSW-1] ? dneg_val[LW-1:0] : d2_reg[LW-1:0];
            dneg3_reg  <= d2_reg[DSW-1];
            degen3_reg <= (d2_reg == '0);
            plx1_reg   <= lul_s * vy2_reg;
            plx2_reg   <= lvl_s * uy2_reg;
            phx1_reg   <= luh_s * vy2_reg;
            phx2_reg   <= lvh_s * uy2_reg;
            ply1_reg   <= lvl_s * ux2_reg;
            ply2_reg   <= lul_s * vx2_reg;
            phy1_reg   <= lvh_s * ux2_reg;
            phy2_reg   <= luh_s * vx2_reg;
        end
    end

    // stage 4: numerators
    logic signed [C-1:0]   a4x_reg, a4y_reg;
    logic signed [NSW-1:0] nx4_reg, ny4_reg;
    logic [LW-1:0]         dmag4_reg;
    logic                  dneg4_reg, degen4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a4x_reg    <= a3x_reg;
            a4y_reg    <= a3y_reg;
            dmag4_reg  <= dmag3_reg;
            dneg4_reg  <= dneg3_reg;
            degen4_reg <= degen3_reg;
            nx4_reg    <= ((widen(phx1_reg) - widen(phx2_reg)) <<< K)
                          + (widen(plx1_reg) - widen(plx2_reg));
            ny4_reg    <= ((widen(phy1_reg) - widen(phy2_reg)) <<< K)
                          + (widen(ply1_reg) - widen(ply2_reg));
        end
    end

    // stage 5: magnitudes, rounding bias and divisor
    logic signed [NSW-1:0] nxn, nyn;
    logic [MAGW-1:0]       magx, magy;
    logic [NUM_W-1:0]      num_x_reg, num_y_reg;
    logic [DEN_W-1:0]      den_reg;
    tcc_tag_t              tag_reg;
    logic signed [C-1:0]   a5x_reg, a5y_reg;

    assign nxn  = -nx4_reg;
    assign nyn  = -ny4_reg;
    assign magx = nx4_reg[NSW-1] ? nxn[MAGW-1:0] : nx4_reg[MAGW-1:0];
    assign magy = ny4_reg[NSW-1] ? nyn[MAGW-1:0] : ny4_reg[MAGW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            num_x_reg     <= (NUM_W'(magx) << FRAC_BITS) + NUM_W'(dmag4_reg);
            num_y_reg     <= (NUM_W'(magy) << FRAC_BITS) + NUM_W'(dmag4_reg);
            den_reg       <= {dmag4_reg, 1'b0};
            tag_reg.degen <= degen4_reg;
            tag_reg.xneg  <= nx4_reg[NSW-1] ^ dneg4_reg;
            tag_reg.yneg  <= ny4_reg[NSW-1] ^ dneg4_reg;
            a5x_reg       <= a4x_reg;
            a5y_reg       <= a4y_reg;
        end
    end

    // valid bits follow the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    assign out_vld = vld_reg[5];
    assign num_x   = num_x_reg;
    assign num_y   = num_y_reg;
    assign den     = den_reg;
    assign tag     = tag_reg;
    assign ax_out  = a5x_reg;
    assign ay_out  = a5y_reg;

endmodule

`default_nettype wire

// File: src/tcc_div.sv
// ---------------------------------------------------------------------------
// tcc_div
// Two-lane restoring divider, one quotient bit per register stage, with a
// shared divisor. Numerator bits shift out at the top, quotient bits in.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_div #(
    parameter int NUM_W  = 3 * tcc_pkg::COORD_BITS_DEF + 3 + tcc_pkg::FRAC_BITS_DEF,
    parameter int DEN_W  = 2 * tcc_pkg::COORD_BITS_DEF + 2,
    parameter int SIDE_W = 2 * tcc_pkg::COORD_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num_x,
    input  logic [NUM_W-1:0]  num_y,
    input  logic [DEN_W-1:0]  den,
    input  tcc_pkg::tcc_tag_t tag_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [NUM_W-1:0]  q_x,
    output logic [NUM_W-1:0]  q_y,
    output tcc_pkg::tcc_tag_t tag_out,
    output logic [SIDE_W-1:0] side_out
);
    import tcc_pkg::*;

    localparam int STAGES = NUM_W;

    // one restoring step: returns {remainder, shifted numerator/quotient}
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] nq,
        input logic [DEN_W-1:0] dv
    );
        logic [DEN_W:0]   cur;
        logic [DEN_W+1:0] diff;
        logic             take;
        logic [DEN_W-1:0] rem_n;
        cur   = {rem, nq[NUM_W-1]};
        diff  = {1'b0, cur} - {2'b00, dv};
        take  = !diff[DEN_W+1];
        rem_n = take ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        return {rem_n, nq[NUM_W-2:0], take};
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [NUM_W-1:0]  nqx_reg  [STAGES];
    logic [NUM_W-1:0]  nqy_reg  [STAGES];
    logic [DEN_W-1:0]  remx_reg [STAGES];
    logic [DEN_W-1:0]  remy_reg [STAGES];
    logic [DEN_W-1:0]  den_reg  [STAGES];
    tcc_tag_t          tag_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic              pvld  [STAGES];
    logic [NUM_W-1:0]  pnqx  [STAGES];
    logic [NUM_W-1:0]  pnqy  [STAGES];
    logic [DEN_W-1:0]  premx [STAGES];
    logic [DEN_W-1:0]  premy [STAGES];
    logic [DEN_W-1:0]  pden  [STAGES];
    tcc_tag_t          ptag  [STAGES];
    logic [SIDE_W-1:0] pside [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [DEN_W+NUM_W-1:0] stx_next, sty_next;

        // stage input: ports for the first step, previous stage otherwise
        if (k == 0) begin : g_first
            assign pvld[k]  = in_vld;
            assign pnqx[k]  = num_x;
            assign pnqy[k]  = num_y;
            assign premx[k] = '0;
            assign premy[k] = '0;
            assign pden[k]  = den;
            assign ptag[k]  = tag_in;
            assign pside[k] = side_in;
        end else begin : g_next
            assign pvld[k]  = vld_reg[k-1];
            assign pnqx[k]  = nqx_reg[k-1];
            assign pnqy[k]  = nqy_reg[k-1];
            assign premx[k] = remx_reg[k-1];
            assign premy[k] = remy_reg[k-1];
            assign pden[k]  = den_reg[k-1];
            assign ptag[k]  = tag_reg[k-1];
            assign pside[k] = side_reg[k-1];
        end

        assign stx_next = div_step(premx[k], pnqx[k], pden[k]);
        assign sty_next = div_step(premy[k], pnqy[k], pden[k]);

        always_ff @(posedge aclk) begin
            if (en) begin
                remx_reg[k] <= stx_next[DEN_W+NUM_W-1:NUM_W];
                nqx_reg[k]  <= stx_next[NUM_W-1:0];
                remy_reg[k] <= sty_next[DEN_W+NUM_W-1:NUM_W];
                nqy_reg[k]  <= sty_next[NUM_W-1:0];
                den_reg[k]  <= pden[k];
                tag_reg[k]  <= ptag[k];
                side_reg[k] <= pside[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= pvld[k];
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign q_x      = nqx_reg[STAGES-1];
    assign q_y      = nqy_reg[STAGES-1];
    assign tag_out  = tag_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: src/tcc_sqrt.sv
// ---------------------------------------------------------------------------
// tcc_sqrt
// Digit-by-digit integer square root, one root bit per register stage.
// Gives the floor root and the remainder s - root^2.
// ---------------------------------------------------------------------------
`default_nettype none

module tcc_sqrt #(
    parameter int SIDE_W = 2 * tcc_pkg::OUT_W
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic [tcc_pkg::SQ_W-1:0]  sq_in,
    input  tcc_pkg::tcc_rtag_t        tag_in,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_vld,
    output logic [tcc_pkg::ROOT_W-1:0] root,
    output logic [tcc_pkg::REM_W-1:0] rem,
    output tcc_pkg::tcc_rtag_t        tag_out,
    output logic [SIDE_W-1:0]         side_out
);
    import tcc_pkg::*;

    localparam int STAGES = SQ_STEPS;
    localparam int STEP_W = REM_W + ROOT_W + SQ_W;

    // one root digit: returns {remainder, root, shifted radicand}
    function automatic logic [STEP_W-1:0] sqrt_step(
        input logic [REM_W-1:0]  r,
        input logic [ROOT_W-1:0] q,
        input logic [SQ_W-1:0]   s
    );
        logic [REM_W+1:0] cur;
        logic [REM_W+2:0] diff;
        logic             take;
        logic [REM_W-1:0] r_n;
        cur  = {r, s[SQ_W-1:SQ_W-2]};
        diff = {1'b0, cur} - (REM_W+3)'({q, 2'b01});
        take = !diff[REM_W+2];
        r_n  = take ? diff[REM_W-1:0] : cur[REM_W-1:0];
        return {r_n, q[ROOT_W-2:0], take, s[SQ_W-3:0], 2'b00};
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [REM_W-1:0]  rem_reg  [STAGES];
    logic [ROOT_W-1:0] root_reg [STAGES];
    logic [SQ_W-1:0]   sq_reg   [STAGES];
    tcc_rtag_t         tag_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic              pvld  [STAGES];
    logic [REM_W-1:0]  prem  [STAGES];
    logic [ROOT_W-1:0] proot [STAGES];
    logic [SQ_W-1:0]   psq   [STAGES];
    tcc_rtag_t         ptag  [STAGES];
    logic [SIDE_W-1:0] pside [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [STEP_W-1:0] st_next;

        if (k == 0) begin : g_first
            assign pvld[k]  = in_vld;
            assign prem[k]  = '0;
            assign proot[k] = '0;
            assign psq[k]   = sq_in;
            assign ptag[k]  = tag_in;
            assign pside[k] = side_in;
        end else begin : g_next
            assign pvld[k]  = vld_reg[k-1];
            assign prem[k]  = rem_reg[k-1];
            assign proot[k] = root_reg[k-1];
            assign psq[k]   = sq_reg[k-1];
            assign ptag[k]  = tag_reg[k-1];
            assign pside[k] = side_reg[k-1];
        end

        assign st_next = sqrt_step(prem[k], proot[k], psq[k]);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= st_next[STEP_W-1:ROOT_W+SQ_W];
                root_reg[k] <= st_next[ROOT_W+SQ_W-1:SQ_W];
                sq_reg[k]   <= st_next[SQ_W-1:0];
                tag_reg[k]  <= ptag[k];
                side_reg[k] <= pside[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= pvld[k];
            end
        end
    end

    assign out_vld  = vld_reg[STAGES-1];
    assign root     = root_reg[STAGES-1];
    assign rem      = rem_reg[STAGES-1];
    assign tag_out  = tag_reg[STAGES-1];
    assign side_out = side_reg[STAGES-1];

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks the triangle circumcircle pipeline. Each triangle beat that is
// accepted is run through a fixed point predictor of center, radius and flags.
// Every result beat is compared with the oldest prediction. Stimulus covers
// extreme coordinates, collinear and saturating triangles, and random
// triangles. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tcc_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int MAX_SHOWN  = 10;
    localparam logic [127:0] OFS_CAP = 128'd1 << OFS_LOG;
    localparam logic [127:0] U32_MAX = 128'hFFFF_FFFF;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [IN_W-1:0] s_ax, s_ay, s_bx, s_by_coord, s_cx, s_cy;
    logic m_valid;
    logic m_ready;
    logic signed [OUT_W-1:0] m_center_x, m_center_y;
    logic [OUT_W-1:0] m_radius;
    logic m_degenerate, m_saturated;

    tcc_res_t circle_q[$];
    int mismatches;
    int idle_cycles;
    int stall_left;
    bit steady_mode;

    triangle_circumcircle_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ax(s_ax), .s_ay(s_ay), .s_bx(s_bx), .s_by_coord(s_by_coord),
        .s_cx(s_cx), .s_cy(s_cy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_center_x(m_center_x), .m_center_y(m_center_y), .m_radius(m_radius),
        .m_degenerate(m_degenerate), .m_saturated(m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // rounded offset magnitude of n * 2^frac / (2d), held at the cap
    function automatic logic [127:0] offset_of(input logic [63:0] nmag,
                                               input logic [63:0] dmag,
                                               inout bit sat);
        logic [127:0] q;
        q = ((128'(nmag) << FRAC) + 128'(dmag)) / (128'(dmag) << 1);
        if (q >= OFS_CAP) begin
            sat = 1'b1;
            q = OFS_CAP;
        end
        return q;
    endfunction

    function automatic longint clip_s32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic tcc_res_t predict_circle(
        input logic signed [15:0] ax, ay, bx, by, cx, cy);
        tcc_res_t res;
        longint ux, uy, vx, vy, d, lu, lv, nx, ny, ox, oy, cenx, ceny;
        logic [63:0] nxm, nym, dm;
        logic [127:0] qx, qy, s, r, c, bitv;
        bit sat;
        sat = 1'b0;
        ux = longint'(bx) - longint'(ax);
        uy = longint'(by) - longint'(ay);
        vx = longint'(cx) - longint'(ax);
        vy = longint'(cy) - longint'(ay);
        d  = ux * vy - uy * vx;
        res = '0;
        if (d == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        lu = ux * ux + uy * uy;
        lv = vx * vx + vy * vy;
        nx = lu * vy - lv * uy;
        ny = lv * ux - lu * vx;
        nxm = (nx < 0) ? -nx : nx;
        nym = (ny < 0) ? -ny : ny;
        dm  = (d < 0) ? -d : d;
        qx = offset_of(nxm, dm, sat);
        qy = offset_of(nym, dm, sat);
        ox = ((nx < 0) != (d < 0)) ? -longint'(qx) : longint'(qx);
        oy = ((ny < 0) != (d < 0)) ? -longint'(qy) : longint'(qy);
        cenx = clip_s32(longint'(ax) * (64'sd1 <<< FRAC) + ox, sat);
        ceny = clip_s32(longint'(ay) * (64'sd1 <<< FRAC) + oy, sat);
        // rounded square root of the squared offset length
        if (qx > U32_MAX || qy > U32_MAX) begin
            sat = 1'b1;
            r = U32_MAX;
        end else begin
            s = qx * qx + qy * qy;
            r = '0;
            for (bitv = 128'd1 << 33; bitv != 0; bitv = bitv >> 1) begin
                c = r | bitv;
                if (s >= c * c) r = c;
            end
            if (s - r * r > r) r = r + 1;
            if (r > U32_MAX) begin
                sat = 1'b1;
                r = U32_MAX;
            end
        end
        res.center_x  = cenx[31:0];
        res.center_y  = ceny[31:0];
        res.radius    = r[31:0];
        res.saturated = sat;
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        if (steady_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one triangle beat, held until accepted
    task automatic send_triangle(input logic signed [15:0] ax, ay, bx, by, cx, cy);
        int gap;
        s_valid    <= 1'b1;
        s_ax       <= ax;
        s_ay       <= ay;
        s_bx       <= bx;
        s_by_coord <= by;
        s_cx       <= cx;
        s_cy       <= cy;
        do @(posedge aclk); while (!s_ready);
        circle_q.push_back(predict_circle(ax, ay, bx, by, cx, cy));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (circle_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        logic signed [15:0] lo, hi;
        lo = -16'sd32768;
        hi = 16'sd32767;
        send_triangle(lo, lo, hi, lo, lo, hi);
        send_triangle(hi, hi, lo, hi, hi, lo);
        send_triangle(lo, hi, hi, lo, hi, hi);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, -1, 0, 0, -1);
        send_triangle(hi, lo, lo, hi, lo, lo);
        send_triangle(3, -7, -5, 11, 9, 2);
        send_triangle(-1, -1, 1, 1, 1, -1);
    endtask

    task automatic test_collinear();
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(5, 5, 5, 5, 9, -3);
        send_triangle(-32768, -32768, 0, 0, 32767, 32767);
        send_triangle(1, 2, 3, 4, 5, 6);
        send_triangle(100, -100, 100, 200, 100, 32767);
    endtask

    task automatic test_saturation();
        // nearly collinear, far apart: center runs away
        send_triangle(-32768, -32768, 32767, 32767, 32767, 32766);
        send_triangle(-32768, 0, 32767, 1, 0, 0);
        send_triangle(-32768, -32767, 32767, 32767, 0, 0);
        send_triangle(32767, 32767, -32768, -32768, -32768, -32767);
        send_triangle(0, 0, 32767, 1, -32768, 0);
        send_triangle(-20000, 10, 20000, 11, 0, 10);
    endtask

    task automatic random_triangle();
        logic signed [15:0] ax, ay, bx, by, cx, cy;
        int kind, k;
        kind = $urandom_range(0, 9);
        ax = 16'($urandom); ay = 16'($urandom); bx = 16'($urandom);
        by = 16'($urandom); cx = 16'($urandom); cy = 16'($urandom);
        if (kind < 3) begin
            // small triangles around a random spot
            bx = ax + $signed(16'($urandom_range(0, 200)) - 16'sd100);
            by = ay + $signed(16'($urandom_range(0, 200)) - 16'sd100);
            cx = ax + $signed(16'($urandom_range(0, 200)) - 16'sd100);
            cy = ay + $signed(16'($urandom_range(0, 200)) - 16'sd100);
        end else if (kind < 5) begin
            // on or next to the line through a and b
            k  = $urandom_range(0, 4);
            bx = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
            by = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
            ax = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            ay = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            cx = ax + 16'(k) * (bx - ax) + 16'($urandom_range(0, 1));
            cy = ay + 16'(k) * (by - ay);
            bx = ax + (bx - ax);
        end
        send_triangle(ax, ay, bx, by, cx, cy);
    endtask

    task automatic test_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) == 0) steady_mode = ~steady_mode;
            random_triangle();
        end
        steady_mode = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (40) random_triangle();
        s_valid <= 1'b0;
        wait_drained();
        @(posedge aclk);
        repeat (40) random_triangle();
    endtask

    // result check, output stalls and watchdog
    always @(posedge aclk) begin
        tcc_res_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (circle_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result beat at %0t", $realtime);
                end else begin
                    want = circle_q.pop_front();
                    if (m_center_x !== want.center_x || m_center_y !== want.center_y ||
                        m_radius !== want.radius || m_degenerate !== want.degenerate ||
                        m_saturated !== want.saturated) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: exp cx=%h cy=%h r=%h dg=%b st=%b",
                                      " act cx=%h cy=%h r=%h dg=%b st=%b"},
                                     want.center_x, want.center_y, want.radius,
                                     want.degenerate, want.saturated,
                                     m_center_x, m_center_y, m_radius,
                                     m_degenerate, m_saturated);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        steady_mode = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        m_ready    = 1'b0;
        s_ax = '0; s_ay = '0; s_bx = '0; s_by_coord = '0; s_cx = '0; s_cy = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_collinear();
        test_saturation();
        test_drain_pause();
        test_random(1050);
        s_valid <= 1'b0;
        wait_drained();
        repeat (150) @(posedge aclk);
        if (mismatches == 0 && circle_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
